// File: rtl/lrukv_pkg.sv
// shared constants and types for the lru key-value cache
`default_nettype none

package lrukv_pkg;

    localparam int DEF_ENTRIES    = 8;
    localparam int DEF_VALUE_BITS = 64;

    localparam int KEY_W   = 64;
    localparam int VALUE_W = 64;
    localparam int CAP_W   = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    typedef enum logic {
        KIND_GET = 1'b0,
        KIND_SET = 1'b1
    } t_kind;

endpackage

`default_nettype wire

// File: rtl/lru_key_value_cache.sv
// fully associative key-value cache with least-recently-used replacement
`default_nettype none

//  channel   | direction | ports                                          | handshake
//  ----------+-----------+------------------------------------------------+------------------
//  command   | in        | i_kind, i_key, i_write_value                   | i_start & !o_busy
//  result    | out       | o_hit, o_read_value, o_evicted, o_evicted_key  | o_done strobe
//  config    | in        | i_cfg_wdata (capacity)                         | i_cfg_we
//
//  a command beat is taken in every cycle: o_busy is held low
//  each command gives one result beat after passing the input register, then one pass
//  of parallel key compare and age update into the result register
//  back-to-back commands see each other's updates, since the state is written in
//  the same cycle that the result register is loaded
//  reset (synchronous, active low) clears the valid bits, ages, fill count and
//  in-flight strobes, and sets capacity to 8; keys and values are left as they are
//  the receiver cannot stall: o_done stands for exactly one cycle

module lru_key_value_cache #(
    parameter int ENTRIES    = lrukv_pkg::DEF_ENTRIES,
    parameter int VALUE_BITS = lrukv_pkg::DEF_VALUE_BITS
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // command channel
    input  wire                               i_start,
    output logic                              o_busy,
    input  wire                               i_kind,
    input  wire  [lrukv_pkg::KEY_W-1:0]       i_key,
    input  wire  [lrukv_pkg::VALUE_W-1:0]     i_write_value,
    // result channel
    output logic                              o_done,
    output logic                              o_hit,
    output logic [lrukv_pkg::VALUE_W-1:0]     o_read_value,
    output logic                              o_evicted,
    output logic [lrukv_pkg::KEY_W-1:0]       o_evicted_key,
    // configuration
    input  wire                               i_cfg_we,
    input  wire  [lrukv_pkg::CAP_W-1:0]       i_cfg_wdata
);

    import lrukv_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [EW-1:0] ENTRIES_E = EW'(ENTRIES);

    // capacity register
    logic [CAP_W-1:0] r_cap;

    // input register
    logic                  r_in_valid;
    logic                  r_in_kind;
    logic [KEY_W-1:0]      r_in_key;
    logic [VALUE_BITS-1:0] r_in_wv;

    // entry storage: each entry's key is compared in place
    logic [ENTRIES-1:0]    r_valid;
    logic [KEY_W-1:0]      r_key   [ENTRIES];
    logic [VALUE_BITS-1:0] r_value [ENTRIES];
    logic [AGE_W-1:0]      r_age   [ENTRIES];
    logic [CNT_W-1:0]      r_count;

    // result register
    logic              r_done;
    logic              r_hit;
    logic [VALUE_W-1:0] r_read_value;
    logic              r_evicted;
    logic [KEY_W-1:0]  r_evicted_key;

    // next-state values
    logic [ENTRIES-1:0] n_valid;
    logic [AGE_W-1:0]   n_age [ENTRIES];
    logic [CNT_W-1:0]   n_count;

    // lookup logic
    logic [ENTRIES-1:0] hit_mask;
    logic [ENTRIES-1:0] hit_sel;
    logic [ENTRIES-1:0] old_mask;
    logic [ENTRIES-1:0] free_mask;
    logic [ENTRIES-1:0] free_sel;
    logic [ENTRIES-1:0] tgt_sel;
    logic [ENTRIES-1:0] key_we;
    logic [ENTRIES-1:0] value_we;
    logic               hit_any;
    logic               is_set;
    logic               full;
    logic               do_evict;
    logic               do_insert;
    logic               do_touch;
    logic [EW-1:0]      cap_e;
    logic [EW-1:0]      eff_cap;
    logic [CNT_W-1:0]   cnt_m1;
    logic [AGE_W-1:0]   oldest_age;
    logic [AGE_W-1:0]   tgt_age;
    logic [VALUE_BITS-1:0] hit_value;
    logic [KEY_W-1:0]   old_key;

    assign o_busy = 1'b0;

    // capacity zero acts as one, above the entry count it saturates
    always_comb begin
        cap_e = EW'(r_cap);
        priority if (cap_e == '0) begin
            eff_cap = EW'(1);
        end else if (cap_e > ENTRIES_E) begin
            eff_cap = ENTRIES_E;
        end else begin
            eff_cap = cap_e;
        end
    end

    assign full   = EW'(r_count) >= eff_cap;
    assign is_set = (r_in_kind == KIND_SET);

    // valid ages are a permutation of 0..count-1, so the oldest sits at count-1
    assign cnt_m1     = r_count - CNT_W'(1);
    assign oldest_age = cnt_m1[AGE_W-1:0];

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            hit_mask[i] = r_valid[i] && (r_key[i] == r_in_key);
            old_mask[i] = r_valid[i] && (r_age[i] == oldest_age);
        end
    end

    assign free_mask = ~r_valid;
    // lowest set bit of each mask
    assign hit_sel   = hit_mask & (~hit_mask + ENTRIES'(1));
    assign free_sel  = free_mask & (~free_mask + ENTRIES'(1));
    assign hit_any   = |hit_mask;

    assign do_evict  = r_in_valid && !hit_any && is_set && full;
    assign do_insert = r_in_valid && !hit_any && is_set && !full;
    assign do_touch  = (r_in_valid && hit_any) || do_evict;

    always_comb begin
        priority if (hit_any) begin
            tgt_sel = hit_sel;
        end else if (full) begin
            tgt_sel = old_mask;
        end else begin
            tgt_sel = free_sel;
        end
    end

    // one-hot read of the selected entries
    always_comb begin
        tgt_age   = '0;
        hit_value = '0;
        old_key   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            tgt_age   = tgt_age   | (r_age[i]   & {AGE_W{tgt_sel[i]}});
            hit_value = hit_value | (r_value[i] & {VALUE_BITS{hit_sel[i]}});
            old_key   = old_key   | (r_key[i]   & {KEY_W{old_mask[i]}});
        end
    end

    // touch: entries younger than the target age by one, target becomes newest;
    // insert: every valid entry ages by one
    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        for (int i = 0; i < ENTRIES; i++) begin
            n_age[i] = r_age[i];
            if ((do_touch || do_insert) && tgt_sel[i]) begin
                n_age[i] = '0;
            end else if (r_valid[i] && (do_insert || (do_touch && (r_age[i] < tgt_age)))) begin
                n_age[i] = r_age[i] + AGE_W'(1);
            end
        end
        if (do_insert) begin
            n_valid = r_valid | tgt_sel;
            n_count = r_count + CNT_W'(1);
        end
    end

    assign key_we   = (do_evict || do_insert) ? tgt_sel : '0;
    assign value_we = (r_in_valid && is_set) ? tgt_sel : '0;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= CAP_RESET;
            r_in_valid <= 1'b0;
            r_done     <= 1'b0;
            r_valid    <= '0;
            r_count    <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_in_valid <= i_start && !o_busy;
            r_done     <= r_in_valid;
            r_valid    <= n_valid;
            r_count    <= n_count;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= n_age[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_in_kind <= i_kind;
            r_in_key  <= i_key;
            r_in_wv   <= i_write_value[VALUE_BITS-1:0];
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (key_we[i]) begin
                r_key[i] <= r_in_key;
            end
            if (value_we[i]) begin
                r_value[i] <= r_in_wv;
            end
        end
        r_hit         <= hit_any;
        r_read_value  <= (hit_any && !is_set) ? VALUE_W'(hit_value) : '0;
        r_evicted     <= do_evict;
        r_evicted_key <= do_evict ? old_key : '0;
    end

    assign o_done        = r_done;
    assign o_hit         = r_hit;
    assign o_read_value  = r_read_value;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evicted_key;

    // fill count tracks the valid bits
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == r_count)
        else $error("fill count differs from number of valid entries");

    // keys stay unique, so at most one entry can match
    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> $onehot0(hit_mask))
        else $error("more than one entry matches the key");

    // a full store always has exactly one oldest entry to evict
    a_one_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_evict |-> $onehot(old_mask))
        else $error("eviction without a unique oldest entry");

    // a command in the input register gives one result beat in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |=> o_done)
        else $error("command lost its result beat");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_hit && o_evicted))
        else $error("hit and eviction in one result");

endmodule

`default_nettype wire
